@@ hdl/vsrm_pkg.sv @@
`timescale 1ns / 1ps

package vsrm_pkg;

	// stream field widths
	localparam int COORD_W   = 5;
	localparam int DENS_W    = 8;
	localparam int SHADOW_W  = 8;
	localparam int S_DATA_W  = 24;
	localparam int M_DATA_W  = 8;

	// fixed-point march position
	localparam int FRAC_BITS = 16;
	localparam int STEP_W    = 16;
	localparam int YPOS_W    = COORD_W + FRAC_BITS;

	// configuration port
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam logic REG_STEP_LENGTH = 1'b0;
	localparam logic [STEP_W-1:0] STEP_RESET = 16'd20972;

	// tuser opcodes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [SHADOW_W-1:0] FULL_SHADOW = 8'hFF;

endpackage

@@ hdl/voxel_shadow_ray_march.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Beat contents (tdata low bit up / tuser)
// s_*      in   tdata: pos_x[4:0], pos_y[9:5], pos_z[14:10], density[22:15], zero[23]
//               tuser: opcode (0 load voxel, 1 shadow query)
// m_*      out  tdata: shadow[7:0]; one beat per query, none per load
// apb      in   step_length at byte address 0, bits [15:0]
//
// A load is written into the voxel memory at its beat. A query marches at most
// MAX_STEPS steps down the column;
// the single-port voxel memory delivers one voxel per cycle to the accumulator.
// s_tready is low while a query marches and while its result waits for the
// output register; the output register holds its beat until m_tready.
// Reset clears control state and sets step_length; voxel contents are undefined.
module voxel_shadow_ray_march #(
	parameter int SIDE      = 32,
	parameter int MAX_STEPS = 100
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// pos_x, pos_y, pos_z, density from bit 0 up, zero filled
	input  logic [vsrm_pkg::S_DATA_W-1:0]   s_tdata,
	// opcode
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// shadow
	output logic [vsrm_pkg::M_DATA_W-1:0]   m_tdata,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [vsrm_pkg::PADDR_W-1:0]    paddr,
	input  logic [vsrm_pkg::PDATA_W-1:0]    pwdata,
	output logic [vsrm_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready
);
	import vsrm_pkg::*;

	localparam int CW    = $clog2(SIDE);
	localparam int AW    = 3 * CW;
	localparam int DEPTH = 1 << AW;
	localparam int CNT_W = $clog2(MAX_STEPS + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MARCH = 2'd1;
	localparam logic [1:0] ST_DONE  = 2'd2;

	logic [1:0]          state_q;
	logic [STEP_W-1:0]   step_q;
	logic [YPOS_W-1:0]   ypos_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SHADOW_W-1:0] sum_q;
	logic [SHADOW_W-1:0] res_q;
	logic [CW-1:0]       x_q;
	logic [CW-1:0]       z_q;
	logic                rvalid_q;
	logic [DENS_W-1:0]   rdata_q;
	logic                out_valid_q;
	logic [SHADOW_W-1:0] shadow_q;

	logic [DENS_W-1:0]   mem [DEPTH];

	logic [COORD_W-1:0]  in_x, in_y, in_z;
	logic [DENS_W-1:0]   in_dens;
	logic [CW+COORD_W-1:0] ext_x, ext_y, ext_z;
	logic [CW+COORD_W-1:0] ext_row;
	logic                in_vol;
	logic                in_beat;
	logic                load_we;
	logic                query_go;
	logic [YPOS_W:0]     ydiff;
	logic                issue;
	logic [SHADOW_W:0]   sum_next;
	logic                ovf;
	logic [AW-1:0]       waddr, raddr;
	logic                out_free;
	logic                cfg_we;

	assign in_x    = s_tdata[COORD_W-1:0];
	assign in_y    = s_tdata[2*COORD_W-1:COORD_W];
	assign in_z    = s_tdata[3*COORD_W-1:2*COORD_W];
	assign in_dens = s_tdata[3*COORD_W+DENS_W-1:3*COORD_W];

	assign ext_x = {{CW{1'b0}}, in_x};
	assign ext_y = {{CW{1'b0}}, in_y};
	assign ext_z = {{CW{1'b0}}, in_z};

	assign in_vol = (int'(in_x) < SIDE) && (int'(in_y) < SIDE) && (int'(in_z) < SIDE);

	assign s_tready = (state_q == ST_IDLE);
	assign in_beat  = s_tvalid && s_tready;
	assign load_we  = in_beat && (s_tuser == OP_LOAD) && in_vol;
	assign query_go = in_beat && (s_tuser == OP_QUERY);

	// one march step: lower y, stop on borrow
	assign ydiff   = {1'b0, ypos_q} - {{(YPOS_W+1-STEP_W){1'b0}}, step_q};
	assign ext_row = {{CW{1'b0}}, ydiff[YPOS_W-1:FRAC_BITS]};

	assign sum_next = {1'b0, sum_q} + {1'b0, (rvalid_q ? rdata_q : {DENS_W{1'b0}})};
	assign ovf      = sum_next[SHADOW_W];
	assign issue    = (state_q == ST_MARCH) && !ovf && !ydiff[YPOS_W]
		&& (cnt_q < CNT_W'(MAX_STEPS));

	assign waddr = {ext_z[CW-1:0], ext_y[CW-1:0], ext_x[CW-1:0]};
	assign raddr = {z_q, ext_row[CW-1:0], x_q};

	always_ff @(posedge clk) begin
		if (load_we) begin
			mem[waddr] <= in_dens;
		end
		if (issue) begin
			rdata_q <= mem[raddr];
		end
	end

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rvalid_q <= 1'b0;
			cnt_q    <= '0;
			sum_q    <= '0;
		end else begin
			rvalid_q <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (query_go) begin
						cnt_q <= '0;
						sum_q <= '0;
						state_q <= in_vol ? ST_MARCH : ST_DONE;
					end
				end
				ST_MARCH: begin
					sum_q <= sum_next[SHADOW_W-1:0];
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// march payload
	always_ff @(posedge clk) begin
		if (query_go) begin
			ypos_q <= {in_y, {FRAC_BITS{1'b0}}};
			x_q    <= ext_x[CW-1:0];
			z_q    <= ext_z[CW-1:0];
			res_q  <= '0;
		end else if (issue) begin
			ypos_q <= ydiff[YPOS_W-1:0];
		end else if (state_q == ST_MARCH) begin
			res_q <= ovf ? FULL_SHADOW : sum_next[SHADOW_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			shadow_q <= res_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = shadow_q;

	// configuration
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_STEP_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_we) begin
			step_q <= pwdata[STEP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_STEP_LENGTH) ? {{(PDATA_W-STEP_W){1'b0}}, step_q}
		: {PDATA_W{1'b0}};

`ifndef NO_ASSERTIONS
	a_read_in_march: assert property (@(posedge clk) disable iff (!arst_n)
		rvalid_q |-> state_q == ST_MARCH)
		else $error("voxel read returned outside the march");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_STEPS))
		else $error("march step count beyond limit");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_DONE)
		else $error("result beat without a finished query");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MARCH) |=> !s_tready || !rvalid_q)
		else $error("input taken while voxel read pending");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import vsrm_pkg::*;

	localparam int SIDE      = 32;
	localparam int MAX_STEPS = 100;
	localparam int LIMIT     = 1000000;
	localparam int N_PHASES  = 8;
	localparam int N_RANDOM  = 146;

	class shadow_board;
		bit [DENS_W-1:0]   voxel_mem [SIDE*SIDE*SIDE];
		bit                loaded    [SIDE*SIDE*SIDE];
		logic [STEP_W-1:0] step_len;
		logic [SHADOW_W-1:0] shadow_q [$];
		int                mismatches;

		function new();
			step_len   = STEP_RESET;
			mismatches = 0;
		endfunction

		function void report(string what, int want, int got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t %s: expected %0d, got %0d", $time, what, want, got);
		endfunction

		// march down the column; ok drops if any voxel on the path was never loaded
		function logic [SHADOW_W-1:0] walk(input logic [COORD_W-1:0] x, y, z, output bit ok);
			int                   ypos;
			int unsigned          acc;
			logic [3*COORD_W-1:0] idx;
			ypos = int'(y) << FRAC_BITS;
			acc  = 0;
			ok   = 1'b1;
			for (int i = 0; i < MAX_STEPS; i++) begin
				ypos = ypos - int'(step_len);
				if (ypos < 0)
					break;
				idx = {z, ypos[FRAC_BITS +: COORD_W], x};
				if (!loaded[idx])
					ok = 1'b0;
				acc += voxel_mem[idx];
				if (acc > FULL_SHADOW)
					break;
			end
			return (acc > FULL_SHADOW) ? FULL_SHADOW : acc[SHADOW_W-1:0];
		endfunction

		function void note_input(logic op, logic [COORD_W-1:0] x, y, z, logic [DENS_W-1:0] d);
			bit ok;
			if (op == OP_LOAD) begin
				voxel_mem[{z, y, x}] = d;
				loaded[{z, y, x}]    = 1'b1;
			end else begin
				shadow_q.push_back(walk(x, y, z, ok));
			end
		endfunction

		function void check(logic [SHADOW_W-1:0] got);
			logic [SHADOW_W-1:0] want;
			if (shadow_q.size() == 0) begin
				report("shadow beat with nothing pending", -1, int'(got));
				return;
			end
			want = shadow_q.pop_front();
			if (got !== want)
				report("shadow", int'(want), int'(got));
		endfunction

		function int pending();
			return shadow_q.size();
		endfunction
	endclass

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// pos_x, pos_y, pos_z, density from bit 0 up, zero filled
	logic [S_DATA_W-1:0]   s_tdata  = '0;
	// opcode
	logic                  s_tuser  = OP_LOAD;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// shadow
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [PADDR_W-1:0]    paddr    = '0;
	logic [PDATA_W-1:0]    pwdata   = '0;
	logic [PDATA_W-1:0]    prdata;
	logic                  pready;

	shadow_board         sb;
	bit                  calm = 1'b0;
	int                  cycles = 0;
	logic [COORD_W-1:0]  col_x [$];
	logic [COORD_W-1:0]  col_z [$];

	voxel_shadow_ray_march #(
		.SIDE      (SIDE),
		.MAX_STEPS (MAX_STEPS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result side: random stalls unless calm, check every accepted beat
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check(m_tdata);
		if (arst_n)
			m_tready <= calm || ($urandom_range(99) >= 13);
	end

	function automatic logic [DENS_W-1:0] pick_density();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return DENS_W'($urandom_range(4));
		else if (r < 80)
			return DENS_W'($urandom_range(20));
		return DENS_W'($urandom_range(255));
	endfunction

	task automatic send_beat(input logic op, input logic [COORD_W-1:0] x, y, z,
			input logic [DENS_W-1:0] d);
		while (!calm && $urandom_range(99) < 13) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {1'b0, d, z, y, x};
		do @(posedge clk); while (!s_tready);
		sb.note_input(op, x, y, z, d);
	endtask

	// dens below zero picks a random density per row
	task automatic fill_column(input logic [COORD_W-1:0] x, z, input int dens);
		for (int r = 0; r < SIDE; r++)
			send_beat(OP_LOAD, x, r[COORD_W-1:0], z,
				(dens < 0) ? pick_density() : dens[DENS_W-1:0]);
		col_x.push_back(x);
		col_z.push_back(z);
	endtask

	// fall back to a fully loaded column when the path would touch unloaded voxels
	task automatic send_query();
		logic [COORD_W-1:0] qx, qy, qz;
		bit                 ok;
		int                 k;
		qx = COORD_W'($urandom);
		qy = COORD_W'($urandom);
		qz = COORD_W'($urandom);
		void'(sb.walk(qx, qy, qz, ok));
		if (!ok) begin
			k  = $urandom_range(col_x.size() - 1);
			qx = col_x[k];
			qz = col_z[k];
		end
		send_beat(OP_QUERY, qx, qy, qz, DENS_W'($urandom));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic apb_xfer(input bit wr, input logic [PDATA_W-1:0] wdata,
			output logic [PDATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= PADDR_W'(4 * REG_STEP_LENGTH);
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata   = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [STEP_W-1:0]  steps [N_PHASES];
		logic [PDATA_W-1:0] rd;
		int                 r;
		int                 k;

		sb = new();
		steps = '{STEP_RESET, 16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, STEP_RESET};
		for (int p = 4; p < 7; p++)
			steps[p] = STEP_W'($urandom_range(2, 65534));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// saturating column, unit column, then path ends and early stop
		fill_column(5'd31, 5'd31, 255);
		fill_column(5'd0, 5'd0, 1);
		send_beat(OP_QUERY, 5'd31, 5'd31, 5'd31, 8'd0);
		send_beat(OP_QUERY, 5'd31, 5'd0, 5'd31, 8'hFF);
		send_beat(OP_QUERY, 5'd0, 5'd31, 5'd0, 8'd0);
		send_beat(OP_QUERY, 5'd0, 5'd1, 5'd0, 8'd0);
		send_beat(OP_LOAD, 5'd0, 5'd5, 5'd0, 8'd0);
		send_beat(OP_LOAD, 5'd0, 5'd4, 5'd0, 8'd255);
		send_beat(OP_QUERY, 5'd0, 5'd6, 5'd0, 8'd0);
		send_beat(OP_QUERY, 5'd0, 5'd31, 5'd0, 8'd0);

		for (int p = 0; p < N_PHASES; p++) begin
			if (p > 0) begin
				drain();
				repeat (MAX_STEPS + 8) @(posedge clk);
				apb_xfer(1'b1, PDATA_W'(steps[p]), rd);
				apb_xfer(1'b0, '0, rd);
				if (rd[STEP_W-1:0] !== steps[p])
					sb.report("step_length readback", int'(steps[p]),
						int'(rd[STEP_W-1:0]));
				sb.step_len = steps[p];
			end
			calm = (p == 1);
			fill_column(COORD_W'($urandom), COORD_W'($urandom), -1);
			fill_column(COORD_W'($urandom), COORD_W'($urandom), -1);
			for (int i = 0; i < N_RANDOM; i++) begin
				// hold the sender until the block has answered everything
				if (i == N_RANDOM / 2)
					drain();
				r = $urandom_range(99);
				if (r < 55) begin
					send_query();
				end else if (r < 80) begin
					k = $urandom_range(col_x.size() - 1);
					send_beat(OP_LOAD, col_x[k], COORD_W'($urandom), col_z[k],
						pick_density());
				end else begin
					send_beat(OP_LOAD, COORD_W'($urandom), COORD_W'($urandom),
						COORD_W'($urandom), DENS_W'($urandom));
				end
			end
		end
		calm = 1'b0;

		drain();
		repeat (MAX_STEPS + 8) @(posedge clk);
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
